### hw/rtl/fpsm_pkg.sv
// fpsm_pkg: command codes, status codes and shared types for the flash page space manager
// no dependencies
package fpsm_pkg;

	typedef enum logic [2:0] {
		MODE_LOAD       = 3'd0,
		MODE_ALLOC      = 3'd1,
		MODE_INVALIDATE = 3'd2,
		MODE_ERASE_ALL  = 3'd3,
		MODE_SEL_COMPACT = 3'd4,
		MODE_COMPACT_DONE = 3'd5,
		MODE_TOTAL_FREE = 3'd6,
		MODE_UNUSED     = 3'd7
	} mode_t;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_FIT   = 2'd1;
	localparam logic [1:0] ST_NO_ERASE = 2'd2;

	localparam logic [31:0] ERASED_AGE   = 32'hFFFF_FFFF;
	localparam int          HEADER_BYTES = 4;
	localparam int          RESULT_CAP   = 8;
	localparam int          LEN_W        = 12;
	localparam int          TOTAL_W      = 15;

	// pad a length up to a multiple of four, 13 bits so 4095 does not wrap
	function automatic logic [12:0] pad4(input logic [11:0] len);
		logic [12:0] s;
		s = {1'b0, len} + 13'd3;
		return {s[12:2], 2'b00};
	endfunction

endpackage

### hw/rtl/fpsm_ram.sv
// fpsm_ram: generic single-port ram with registered read
// no dependencies
module fpsm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

### hw/rtl/flash_page_space_manager.sv
// flash_page_space_manager: per-page age, free and waste bookkeeping for a log-structured store
// depends on fpsm_pkg and fpsm_ram
//
//  channel | signals                                                   | dir
//  in      | in_valid in_ready mode page length page_age free_bytes    | in
//          | waste_bytes available                                     |
//  out     | out_valid out_ready status chosen_page write_offset       | out
//          | occupied_bytes new_age total_free last                    |
//
// a command walks the page table one entry at a time (read, then compare or write);
// load, invalidate and compact done skip the walk and only read then write their page;
// allocate reads its chosen entry again after the walk; erase all counts the pages to erase
// in a first walk so it can mark its final result
// the table lives in one ram of three fields with a single port, which sets the pace
// reset sets newest age to one; the page table is undefined until loaded
// out_valid stalls the walk until each result transaction completes
module flash_page_space_manager #(
	parameter int NUM_PAGES  = 8,
	parameter int PAGE_BYTES = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  mode,
	input  logic [2:0]  page,
	input  logic [11:0] length,
	input  logic [31:0] page_age,
	input  logic [11:0] free_bytes,
	input  logic [11:0] waste_bytes,
	input  logic [15:0] available,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [2:0]  chosen_page,
	output logic [10:0] write_offset,
	output logic [11:0] occupied_bytes,
	output logic [31:0] new_age,
	output logic [14:0] total_free,
	output logic        last
);
	import fpsm_pkg::*;

	localparam int AW    = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
	localparam int CW    = $clog2(NUM_PAGES + 1);
	localparam int EW    = 32 + 2 * LEN_W;
	localparam logic [12:0] PB   = 13'(PAGE_BYTES);
	localparam logic [12:0] PBH  = 13'(PAGE_BYTES - HEADER_BYTES);

	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_EVAL, S_FINAL_RD, S_FINAL_WR, S_OUT
	} state_t;

	state_t          state_q;
	logic [2:0]      mode_q;
	logic [2:0]      page_q;
	logic [12:0]     plen_q;
	logic [31:0]     age_in_q;
	logic [11:0]     free_in_q;
	logic [11:0]     waste_in_q;
	logic [15:0]     avail_q;
	logic [CW-1:0]   idx_q;
	logic [31:0]     newest_q;
	logic [31:0]     best_q;
	logic [AW-1:0]   sel_q;
	logic            found_q;
	logic [15:0]     acc_q;
	logic [3:0]      nerase_q;
	logic            resume_q;
	logic            pre_q;
	logic [CW-1:0]   todo_q;

	logic [1:0]      status_q;
	logic [2:0]      chosen_q;
	logic [10:0]     offset_q;
	logic [11:0]     occ_q;
	logic [31:0]     age_out_q;
	logic [14:0]     total_q;
	logic            last_q;

	logic            ram_we;
	logic [AW-1:0]   ram_addr;
	logic [EW-1:0]   ram_wdata, ram_rdata;
	logic [31:0]     r_age;
	logic [11:0]     r_free, r_waste;

	fpsm_ram #(.WIDTH(EW), .DEPTH(NUM_PAGES)) u_table (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	assign {r_age, r_free, r_waste} = ram_rdata;

	logic        page_ok;
	logic [12:0] used, occ_cur, waste_sum;
	logic [16:0] acc_sum;
	logic [11:0] in_free_sat, in_waste_sat;
	logic        scan_done;

	assign page_ok   = {1'b0, page_q} < 4'(NUM_PAGES);
	assign used      = {1'b0, r_free} + {1'b0, r_waste};
	assign occ_cur   = (used >= PB) ? 13'd0 : PB - used;
	assign waste_sum = {1'b0, r_waste} + plen_q;
	assign acc_sum   = {1'b0, acc_q} + 17'(used);
	assign in_free_sat  = ({1'b0, free_in_q} > PB) ? PB[11:0] : free_in_q;
	assign in_waste_sat = ({1'b0, waste_in_q} > PB) ? PB[11:0] : waste_in_q;
	assign scan_done = (idx_q == CW'(NUM_PAGES - 1));

	// single shared port: address and write data chosen by the sequencer
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = idx_q[AW-1:0];
		ram_wdata = {r_age, r_free, r_waste};
		unique case (state_q)
			S_EVAL: begin
				if (mode_q == MODE_ERASE_ALL && !pre_q && {1'b0, r_free} != PBH) begin
					ram_we    = 1'b1;
					ram_wdata = {newest_q + 32'd1, PBH[11:0], 12'd0};
				end
			end
			S_FINAL_RD: ram_addr = (mode_q == MODE_ALLOC) ? sel_q : page_q[AW-1:0];
			S_FINAL_WR: begin
				ram_addr = (mode_q == MODE_ALLOC) ? sel_q : page_q[AW-1:0];
				unique case (mode_q)
					MODE_LOAD: begin
						ram_we = page_ok;
						ram_wdata = {age_in_q, in_free_sat, in_waste_sat};
					end
					MODE_ALLOC: begin
						ram_we = found_q;
						ram_wdata = {r_age, r_free - plen_q[11:0], r_waste};
					end
					MODE_INVALIDATE: begin
						ram_we = page_ok;
						ram_wdata = {r_age, r_free, (waste_sum > PB) ? PB[11:0] : waste_sum[11:0]};
					end
					MODE_COMPACT_DONE: begin
						ram_we = page_ok;
						ram_wdata = {newest_q + 32'd1,
							(13'(plen_q + 13'(HEADER_BYTES)) >= PB) ? 12'd0 : 12'(PBH - plen_q),
							12'd0};
					end
					default: ram_we = 1'b0;
				endcase
			end
			default: ram_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			newest_q <= 32'd1;
			idx_q    <= '0;
			resume_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && mode != MODE_UNUSED) begin
						mode_q     <= mode;
						page_q     <= page;
						plen_q     <= pad4(length);
						age_in_q   <= page_age;
						free_in_q  <= free_bytes;
						waste_in_q <= waste_bytes;
						avail_q    <= available;
						idx_q      <= '0;
						best_q     <= ERASED_AGE;
						sel_q      <= '0;
						found_q    <= 1'b0;
						acc_q      <= '0;
						nerase_q   <= '0;
						pre_q      <= (mode == MODE_ERASE_ALL);
						todo_q     <= '0;
						status_q   <= ST_OK;
						chosen_q   <= page;
						offset_q   <= '0;
						occ_q      <= '0;
						age_out_q  <= '0;
						total_q    <= '0;
						last_q     <= 1'b1;
						unique case (mode)
							MODE_LOAD, MODE_INVALIDATE, MODE_COMPACT_DONE:
								state_q <= S_FINAL_RD;
							default: state_q <= S_READ;
						endcase
					end
				end
				S_READ: state_q <= S_EVAL;
				S_EVAL: begin
					state_q <= S_READ;
					idx_q   <= idx_q + CW'(1);
					case (mode_q)
						MODE_ALLOC: begin
							if (r_age < best_q && {1'b0, r_free} >= plen_q) begin
								best_q  <= r_age;
								sel_q   <= idx_q[AW-1:0];
								found_q <= 1'b1;
							end
						end
						MODE_SEL_COMPACT: begin
							if (r_age < best_q && PB - occ_cur >= plen_q
								&& {3'b0, occ_cur} <= avail_q) begin
								best_q  <= r_age;
								sel_q   <= idx_q[AW-1:0];
								found_q <= 1'b1;
								occ_q   <= occ_cur[11:0];
							end
						end
						MODE_TOTAL_FREE:
							acc_q <= acc_sum[16] ? 16'hFFFF : acc_sum[15:0];
						MODE_ERASE_ALL: begin
							if (pre_q) begin
								// first walk only counts the pages to erase
								if ({1'b0, r_free} != PBH)
									todo_q <= todo_q + CW'(1);
							end else if ({1'b0, r_free} != PBH) begin
								newest_q <= newest_q + 32'd1;
								if (nerase_q < 4'(RESULT_CAP)) begin
									nerase_q  <= nerase_q + 4'd1;
									chosen_q  <= 3'(idx_q);
									age_out_q <= newest_q + 32'd1;
									status_q  <= ST_OK;
									last_q    <= (CW'(nerase_q) + CW'(1) == todo_q)
										|| (nerase_q == 4'(RESULT_CAP - 1));
									resume_q  <= (CW'(nerase_q) + CW'(1) != todo_q);
									state_q   <= S_OUT;
								end
							end
						end
						default: ;
					endcase
					if (scan_done && mode_q == MODE_ERASE_ALL && pre_q) begin
						pre_q <= 1'b0;
						idx_q <= '0;
					end
					if (scan_done && !(mode_q == MODE_ERASE_ALL && (pre_q
						|| ({1'b0, r_free} != PBH && nerase_q < 4'(RESULT_CAP))))) begin
						state_q  <= S_OUT;
						resume_q <= 1'b0;
						last_q   <= 1'b1;
						case (mode_q)
							MODE_ALLOC: begin
								// offset needs the chosen entry again
								if (found_q || (r_age < best_q && {1'b0, r_free} >= plen_q))
									state_q <= S_FINAL_RD;
								else begin
									status_q <= ST_NO_FIT;
									chosen_q <= '0;
								end
							end
							MODE_SEL_COMPACT: begin
								if (found_q || (r_age < best_q && PB - occ_cur >= plen_q
									&& {3'b0, occ_cur} <= avail_q))
									chosen_q <= (r_age < best_q && PB - occ_cur >= plen_q
										&& {3'b0, occ_cur} <= avail_q)
										? 3'(idx_q) : 3'(sel_q);
								else begin
									status_q <= ST_NO_FIT;
									chosen_q <= '0;
								end
							end
							MODE_TOTAL_FREE: begin
								chosen_q <= '0;
								total_q  <= (acc_sum > 17'h7FFF) ? 15'h7FFF : acc_sum[14:0];
							end
							MODE_ERASE_ALL: begin
								if (nerase_q == '0) begin
									status_q <= ST_NO_ERASE;
									chosen_q <= '0;
									age_out_q <= '0;
								end else
									state_q <= S_IDLE; // final result already shown
							end
							default: ;
						endcase
					end
				end
				S_FINAL_RD: begin
					found_q <= 1'b1;
					state_q <= S_FINAL_WR;
				end
				S_FINAL_WR: begin
					state_q <= S_OUT;
					unique case (mode_q)
						MODE_LOAD: begin
							if (page_ok && age_in_q != ERASED_AGE && age_in_q > newest_q)
								newest_q <= age_in_q;
						end
						MODE_ALLOC: begin
							chosen_q <= 3'(sel_q);
							offset_q <= 11'(PB - {1'b0, r_free});
						end
						MODE_COMPACT_DONE: begin
							if (page_ok) begin
								newest_q  <= newest_q + 32'd1;
								age_out_q <= newest_q + 32'd1;
							end
						end
						default: ;
					endcase
				end
				S_OUT: begin
					if (out_ready) begin
						state_q <= resume_q ? S_READ : S_IDLE;
						resume_q <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready       = (state_q == S_IDLE);
	assign out_valid      = (state_q == S_OUT);
	assign status         = status_q;
	assign chosen_page    = chosen_q;
	assign write_offset   = offset_q;
	assign occupied_bytes = occ_q;
	assign new_age        = age_out_q;
	assign total_free     = total_q;
	assign last           = last_q;

	// a result never waits while the block also takes a command
	assert property (@(posedge clk) disable iff (!arst_n) !(in_ready && out_valid))
		else $error("input and output both open");
	// the run's final result ends with a return to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=> in_ready)
		else $error("final result not followed by idle");
	// newest age holds while idle (it never falls except by wrap on a fresh age)
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |=> $stable(newest_q))
		else $error("newest age moved while idle");
endmodule
